/* rtl/srr_pkg.sv */
`default_nettype none

package srr_pkg;

    localparam int WORD_W = 32;
    localparam int SPAN_W = WORD_W + 1;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = WORD_W;
    localparam int NUM_CFG_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_THIRD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNTER = 3'd3;

    localparam logic [WORD_W-1:0] SEED_FIRST_RESET = 32'd0;
    localparam logic [WORD_W-1:0] SEED_SECOND_RESET = 32'd12345;
    localparam logic [WORD_W-1:0] SEED_THIRD_RESET = 32'd0;
    localparam logic [WORD_W-1:0] SEED_COUNTER_RESET = 32'd1;

    localparam int DEFAULT_WARMUP_STEPS = 12;

    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int SHIFT_FIRST = 9;
    localparam int SHIFT_SECOND = 3;
    localparam int ROT_THIRD = 21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_WARM,
        ST_STEP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic load_seed;
        logic advance;
        logic capture;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic inverted;
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
        logic [WORD_W-1:0] third;
        logic [WORD_W-1:0] count;
    } gen_t;

    function automatic gen_t gen_advance(input gen_t cur);
        gen_t nxt;
        nxt.first = cur.second ^ (cur.second >> SHIFT_FIRST);
        nxt.second = cur.third + (cur.third << SHIFT_SECOND);
        nxt.third = ((cur.third << ROT_THIRD) | (cur.third >> (WORD_W - ROT_THIRD)))
                    + (cur.first + cur.second + cur.count);
        nxt.count = cur.count + 32'd1;
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfc32_ranged_random_unit.sv */
// Channel  | Signals                         | Contents
// ---------+---------------------------------+------------------------------------------
// request  | s_tvalid s_tready s_tdata[63:0] | range_low, range_high
// result   | m_tvalid m_tready m_tdata[63:0] | ranged_value, raw_word; m_tuser: range_error
// config   | wr_en wr_index wr_data[31:0]    | seed_first, seed_second, seed_third, seed_counter
//
// A seeded request runs one generator step, then a restoring remainder unit that
// retires one quotient bit per cycle. An inverted range skips the remainder unit.
// The first request after reset or after a seed write first loads the seeds and then
// runs WARMUP_STEPS warm-up steps of the generator.
// Reset loads the seed defaults and leaves the generator unseeded.
// A finished result waits in the output register; the next request is taken meanwhile.
`default_nettype none

module sfc32_ranged_random_unit #(
    parameter int WARMUP_STEPS = srr_pkg::DEFAULT_WARMUP_STEPS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: range_low[31:0], range_high[63:32].
    input  wire logic [2*srr_pkg::WORD_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: ranged_value[31:0], raw_word[63:32].
    output logic [2*srr_pkg::WORD_W-1:0]        m_tdata,
    // Fields from bit 0: range_error[0].
    output logic [0:0]                          m_tuser,
    input  wire logic                           wr_en,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0] wr_data
);
    import srr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    cfg_hit;

    assign cfg_hit = wr_en && (wr_index < CFG_IDX_W'(NUM_CFG_REGS));

    srr_ctrl #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_hit  (cfg_hit),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_tdata),
        .out_err  (m_tuser[0])
    );

endmodule

`default_nettype wire

/* rtl/srr_datapath.sv */
`default_nettype none

module srr_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [srr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [srr_pkg::CFG_DATA_W-1:0] wr_data,
    input  wire logic [2*srr_pkg::WORD_W-1:0]   in_data,
    input  wire srr_pkg::cmd_t                  cmd,
    output srr_pkg::status_t                    status,
    output logic [2*srr_pkg::WORD_W-1:0]        out_data,
    output logic                                out_err
);
    import srr_pkg::*;

    logic [WORD_W-1:0] seed_first_reg;
    logic [WORD_W-1:0] seed_second_reg;
    logic [WORD_W-1:0] seed_third_reg;
    logic [WORD_W-1:0] seed_counter_reg;

    gen_t              gen_reg;
    gen_t              gen_next;
    logic [WORD_W-1:0] word_next;

    logic [WORD_W-1:0] lo_reg;
    logic [WORD_W-1:0] hi_reg;
    logic [WORD_W-1:0] raw_reg;
    logic [WORD_W-1:0] dividend_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] rem_next;
    logic [SPAN_W:0]   trial;
    logic [WORD_W-1:0] mag;

    logic [WORD_W-1:0] value_out_reg;
    logic [WORD_W-1:0] raw_out_reg;
    logic              err_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_first_reg   <= SEED_FIRST_RESET;
            seed_second_reg  <= SEED_SECOND_RESET;
            seed_third_reg   <= SEED_THIRD_RESET;
            seed_counter_reg <= SEED_COUNTER_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SEED_FIRST:   seed_first_reg   <= wr_data;
                REG_SEED_SECOND:  seed_second_reg  <= wr_data;
                REG_SEED_THIRD:   seed_third_reg   <= wr_data;
                REG_SEED_COUNTER: seed_counter_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        gen_next  = gen_advance(gen_reg);
        word_next = gen_reg.first + gen_reg.second + gen_reg.count;
        mag       = word_next[WORD_W-1] ? (~word_next + 32'd1) : word_next;
        trial     = {rem_reg, dividend_reg[WORD_W-1]};
        if (trial >= {1'b0, span_reg})
        begin
            rem_next = SPAN_W'(trial - {1'b0, span_reg});
        end
        else
        begin
            rem_next = trial[SPAN_W-1:0];
        end
    end

    assign status.inverted = $signed(hi_reg) < $signed(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= '0;
        end
        else if (cmd.load_seed)
        begin
            gen_reg.first  <= seed_first_reg;
            gen_reg.second <= seed_second_reg;
            gen_reg.third  <= seed_third_reg;
            gen_reg.count  <= seed_counter_reg;
        end
        else if (cmd.advance)
        begin
            gen_reg <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lo_reg <= in_data[WORD_W-1:0];
            hi_reg <= in_data[2*WORD_W-1:WORD_W];
        end
        if (cmd.capture)
        begin
            raw_reg      <= word_next;
            dividend_reg <= mag;
            span_reg     <= {1'b0, hi_reg - lo_reg} + 33'd1;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[WORD_W-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
        if (cmd.load_out)
        begin
            raw_out_reg   <= raw_reg;
            err_out_reg   <= status.inverted;
            value_out_reg <= status.inverted ? lo_reg : (lo_reg + rem_reg[WORD_W-1:0]);
        end
    end

    assign out_data = {raw_out_reg, value_out_reg};
    assign out_err  = err_out_reg;

endmodule

`default_nettype wire

/* rtl/srr_ctrl.sv */
`default_nettype none

module srr_ctrl #(
    parameter int WARMUP_STEPS = srr_pkg::DEFAULT_WARMUP_STEPS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire logic             cfg_hit,
    input  wire srr_pkg::status_t status,
    output srr_pkg::cmd_t         cmd
);
    import srr_pkg::*;

    localparam int WCNT_W = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

    state_t              state_reg;
    state_t              state_next;
    logic                seeded_reg;
    logic [WCNT_W-1:0]   wcnt_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic                out_valid_reg;
    logic                out_free;
    logic                in_xfer;
    logic                warm_last;
    logic                div_last;

    assign out_free  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign warm_last = wcnt_reg == WCNT_W'(WARMUP_STEPS - 1);
    assign div_last  = dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = seeded_reg ? ST_STEP : ST_SEED;
                end
            end
            ST_SEED:
            begin
                state_next = (WARMUP_STEPS > 0) ? ST_WARM : ST_STEP;
            end
            ST_WARM:
            begin
                if (warm_last)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = status.inverted ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_SEED:   cmd.load_seed = 1'b1;
            ST_WARM:   cmd.advance = 1'b1;
            ST_STEP:
            begin
                cmd.advance = 1'b1;
                cmd.capture = 1'b1;
            end
            ST_DIVIDE: cmd.div_step = 1'b1;
            ST_FINISH: cmd.load_out = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            wcnt_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit)
            begin
                seeded_reg <= 1'b0;
            end
            else if (state_reg == ST_STEP)
            begin
                seeded_reg <= 1'b1;
            end
            if (state_reg == ST_WARM)
            begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            else
            begin
                wcnt_reg <= '0;
            end
            if (state_reg == ST_DIVIDE)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            else
            begin
                dcnt_reg <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken result");

    a_unseeded_reseeds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !seeded_reg) |=> (state_reg == ST_SEED))
        else $error("unseeded request did not load the seeds");

    a_divide_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && !status.inverted) |=>
        (state_reg == ST_DIVIDE && dcnt_reg == '0))
        else $error("division did not start from step zero");

    a_finish_presents: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

/* sim/sfc32_ranged_random_unit_tb.sv */
`timescale 1ns / 1ps

module sfc32_ranged_random_unit_tb;
    import srr_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 600;
    localparam int MODES = 3;
    localparam int SEGMENTS = 6;
    localparam int SEGMENT_ITEMS = 64;

    localparam logic [WORD_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    // Multiplicative inverse of 9 modulo 2**32.
    localparam logic [WORD_W-1:0] INV_NINE = 32'h38E3_8E39;

    localparam logic RANGE_OK = 1'b0;
    localparam logic RANGE_INVERTED = 1'b1;

    localparam logic [WORD_W-1:0] EDGE_VALUES [7] = '{
        32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF
    };

    typedef enum int {
        SEEDS_RANDOM,
        SEEDS_ZERO,
        SEEDS_ONES,
        SEEDS_PARTIAL,
        SEEDS_STRAY_ONLY
    } seed_plan_t;

    typedef struct packed {
        logic [WORD_W-1:0] ranged_value;
        logic [WORD_W-1:0] raw_word;
        logic              range_error;
    } draw_t;

    typedef struct packed {
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] high;
        logic              plant;
        logic              typed;
        logic [WORD_W-1:0] value;
        logic              err;
    } directed_row_t;

    // Rows marked plant are sent right after seeds are loaded that make the
    // first word of the request the most negative word.
    localparam int DIRECTED_ROWS = 20;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, RANGE_OK},
        '{32'h0000_0005, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0005, RANGE_OK},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, RANGE_OK},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, RANGE_OK},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, RANGE_INVERTED},
        '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001, RANGE_INVERTED},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, RANGE_INVERTED},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'hFFFF_FF9C, 32'h0000_0064, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b1, 32'h5555_5555, RANGE_INVERTED},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000, RANGE_OK},
        '{32'h8000_0001, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0001, RANGE_INVERTED},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, RANGE_OK},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, RANGE_OK},
        '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, RANGE_OK},
        '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, RANGE_OK}
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*WORD_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*WORD_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    logic [WORD_W-1:0] seed_regs [NUM_CFG_REGS];
    gen_t              sfc_state;
    bit                sfc_seeded;
    draw_t             pending_draws [$];

    int failures = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    sfc32_ranged_random_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] sfc_advance();
        logic [WORD_W-1:0] out;
        logic [WORD_W-1:0] old_third;
        out = sfc_state.first + sfc_state.second + sfc_state.count;
        old_third = sfc_state.third;
        sfc_state.first = sfc_state.second ^ (sfc_state.second >> SHIFT_FIRST);
        sfc_state.second = old_third + (old_third << SHIFT_SECOND);
        sfc_state.third = {old_third[WORD_W-ROT_THIRD-1:0], old_third[WORD_W-1:WORD_W-ROT_THIRD]}
                          + out;
        sfc_state.count = sfc_state.count + 32'd1;
        return out;
    endfunction

    function automatic draw_t sfc_draw(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        draw_t             d;
        logic [WORD_W:0]   span;
        logic [WORD_W:0]   mag;
        logic [WORD_W:0]   rem;
        logic [WORD_W-1:0] neg;
        if (!sfc_seeded)
        begin
            sfc_state.first = seed_regs[REG_SEED_FIRST];
            sfc_state.second = seed_regs[REG_SEED_SECOND];
            sfc_state.third = seed_regs[REG_SEED_THIRD];
            sfc_state.count = seed_regs[REG_SEED_COUNTER];
            for (int i = 0; i < DEFAULT_WARMUP_STEPS; i++)
                void'(sfc_advance());
            sfc_seeded = 1'b1;
        end
        d.raw_word = sfc_advance();
        if ((hi ^ MOST_NEG) < (lo ^ MOST_NEG))
        begin
            d.range_error = RANGE_INVERTED;
            d.ranged_value = lo;
        end
        else
        begin
            span = {1'b0, hi ^ MOST_NEG} - {1'b0, lo ^ MOST_NEG} + 33'd1;
            neg = -d.raw_word;
            mag = d.raw_word[WORD_W-1] ? {1'b0, neg} : {1'b0, d.raw_word};
            rem = mag % span;
            d.range_error = RANGE_OK;
            d.ranged_value = lo + rem[WORD_W-1:0];
        end
        return d;
    endfunction

    function automatic logic [2*WORD_W-1:0] random_bounds();
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W:0]   top;
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 9))
            3, 4, 5:
            begin
                top = {1'b0, lo ^ MOST_NEG} + 33'($urandom_range(0, 1000));
                hi = (top[WORD_W] ? ALL_ONES : top[WORD_W-1:0]) ^ MOST_NEG;
            end
            6:
            begin
                lo = 32'($urandom_range(0, 200)) - 32'd100;
                hi = lo + 32'($urandom_range(0, 200));
            end
            7:
            begin
                lo = EDGE_VALUES[$urandom_range(0, 6)];
                hi = EDGE_VALUES[$urandom_range(0, 6)];
            end
            8:
            begin
                lo = $urandom_range(0, 1) ? MOST_NEG + 32'($urandom_range(0, 3))
                                          : ALL_ONES - 32'($urandom_range(0, 3));
                hi = MOST_POS - 32'($urandom_range(0, 3));
            end
            9:
                hi = (lo == MOST_NEG) ? MOST_POS : lo - 32'd1;
            default:
                ;
        endcase
        return {hi, lo};
    endfunction

    task automatic send_request(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                                input logic typed, input logic [WORD_W-1:0] value,
                                input logic err);
        draw_t d;
        int    gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {hi, lo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        d = sfc_draw(lo, hi);
        if (typed)
        begin
            d.ranged_value = value;
            d.range_error = err;
        end
        pending_draws.push_back(d);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_seeds(input gen_t seeds, input logic [NUM_CFG_REGS-1:0] mask,
                                 input bit stray);
        logic [WORD_W-1:0] vals [NUM_CFG_REGS];
        vals[REG_SEED_FIRST] = seeds.first;
        vals[REG_SEED_SECOND] = seeds.second;
        vals[REG_SEED_THIRD] = seeds.third;
        vals[REG_SEED_COUNTER] = seeds.count;
        for (int i = 0; i < NUM_CFG_REGS; i++)
        begin
            if (mask[i])
            begin
                wr_en <= 1'b1;
                wr_index <= CFG_IDX_W'(i);
                wr_data <= vals[i];
                seed_regs[i] = vals[i];
                sfc_seeded = 1'b0;
                @(posedge clk);
            end
        end
        if (stray)
        begin
            wr_en <= 1'b1;
            wr_index <= CFG_IDX_W'($urandom_range(NUM_CFG_REGS, 2**CFG_IDX_W - 1));
            wr_data <= $urandom;
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        draw_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                $display("%0t: result with nothing expected: value %h raw %h error %b",
                         $time, m_tdata[WORD_W-1:0], m_tdata[2*WORD_W-1:WORD_W], m_tuser[0]);
                failures++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (m_tdata[WORD_W-1:0] !== want.ranged_value)
                begin
                    $display("%0t: ranged_value expected %h, got %h",
                             $time, want.ranged_value, m_tdata[WORD_W-1:0]);
                    failures++;
                end
                if (m_tdata[2*WORD_W-1:WORD_W] !== want.raw_word)
                begin
                    $display("%0t: raw_word expected %h, got %h",
                             $time, want.raw_word, m_tdata[2*WORD_W-1:WORD_W]);
                    failures++;
                end
                if (m_tuser[0] !== want.range_error)
                begin
                    $display("%0t: range_error expected %b, got %b",
                             $time, want.range_error, m_tuser[0]);
                    failures++;
                end
            end
        end
    end

    initial
    begin : stimulus
        gen_t              planted;
        gen_t              prior;
        gen_t              seeds;
        logic [WORD_W-1:0] mixed;
        logic [2*WORD_W-1:0] bounds;
        seed_plan_t        plan;

        seed_regs[REG_SEED_FIRST] = SEED_FIRST_RESET;
        seed_regs[REG_SEED_SECOND] = SEED_SECOND_RESET;
        seed_regs[REG_SEED_THIRD] = SEED_THIRD_RESET;
        seed_regs[REG_SEED_COUNTER] = SEED_COUNTER_RESET;
        sfc_state = '0;
        sfc_seeded = 1'b0;

        // Walk the generator backwards from a state whose next word is the most
        // negative word, so that these seeds produce it right after warm-up.
        planted.second = 32'h0123_4567;
        planted.third = 32'h89AB_CDEF;
        planted.count = 32'h0000_0100;
        planted.first = MOST_NEG - planted.second - planted.count;
        for (int i = 0; i < DEFAULT_WARMUP_STEPS; i++)
        begin
            prior.count = planted.count - 32'd1;
            prior.third = planted.second * INV_NINE;
            mixed = planted.first;
            prior.second = mixed ^ (mixed >> SHIFT_FIRST) ^ (mixed >> 2*SHIFT_FIRST)
                           ^ (mixed >> 3*SHIFT_FIRST);
            prior.first = planted.third
                          - {prior.third[WORD_W-ROT_THIRD-1:0], prior.third[WORD_W-1:WORD_W-ROT_THIRD]}
                          - prior.second - prior.count;
            planted = prior;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 78;
        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (DIRECTED[row].plant)
            begin
                drain_results();
                program_seeds(planted, '1, 1'b0);
            end
            send_request(DIRECTED[row].low, DIRECTED[row].high, DIRECTED[row].typed,
                         DIRECTED[row].value, DIRECTED[row].err);
        end

        // A write beyond the register list must leave the sequence running.
        drain_results();
        program_seeds('0, '0, 1'b1);

        for (int mode = 0; mode < MODES; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                drain_results();
                seeds = {$urandom, $urandom, $urandom, $urandom};
                plan = seed_plan_t'($urandom_range(SEEDS_RANDOM, SEEDS_STRAY_ONLY));
                if (seg == 1)
                    plan = SEEDS_ZERO;
                if (seg == 2)
                    plan = SEEDS_ONES;
                case (plan)
                    SEEDS_ZERO:       program_seeds('0, '1, 1'b0);
                    SEEDS_ONES:       program_seeds('1, '1, 1'b0);
                    SEEDS_PARTIAL:    program_seeds(seeds, NUM_CFG_REGS'($urandom_range(1, 15)),
                                                    1'($urandom_range(0, 1)));
                    SEEDS_STRAY_ONLY: program_seeds(seeds, '0, 1'b1);
                    default:          program_seeds(seeds, '1, 1'($urandom_range(0, 1)));
                endcase
                if (seg == 0)
                    hold_token++;
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                begin
                    bounds = random_bounds();
                    send_request(bounds[WORD_W-1:0], bounds[2*WORD_W-1:WORD_W], 1'b0, '0,
                                 RANGE_OK);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
